// File: src/rrts_pkg.sv
package rrts_pkg;

   localparam int DEF_SLOTS = 16;
   localparam int MASK_W = 16;
   localparam int MASK_IDX_W = 4;
   localparam int SLOT_OUT_W = 4;
   localparam int PHASE_W = 2;
   localparam int CUR_W = 4;
   // wide enough to compare slot numbers up to the largest slot count
   localparam int CMP_W = 7;

   localparam logic KIND_SELECT = 1'b0;
   localparam logic KIND_POLICY = 1'b1;

   typedef struct packed {
      logic inc;
      logic clr;
   } phase_cmd_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] selected_slot;
      logic                  found;
   } result_type;

endpackage

// File: src/rrts_if.sv
interface rrts_req_if
   import rrts_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CUR_W-1:0]  current_slot;
   logic              current_valid;
   logic [MASK_W-1:0] ready_mask;
   logic [MASK_W-1:0] throttled_mask;

   modport source (output valid, kind, current_slot, current_valid, ready_mask,
                   throttled_mask, input ready);
   modport sink (input valid, kind, current_slot, current_valid, ready_mask,
                 throttled_mask, output ready);
endinterface

interface rrts_rsp_if
   import rrts_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [SLOT_OUT_W-1:0] selected_slot;
   logic                  found;

   modport source (output valid, selected_slot, found, input ready);
   modport sink (input valid, selected_slot, found, output ready);
endinterface

// File: src/rrts_phase_file.sv
module rrts_phase_file
   import rrts_pkg::*;
#(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  phase_cmd_type              cmd,
   input  logic [$clog2(SLOTS)-1:0]   idx,
   output logic                       wrap
);

   logic [PHASE_W-1:0] phase_ff [SLOTS];
   logic [PHASE_W-1:0] phase_rd;
   logic [PHASE_W-1:0] phase_inc;

   // shared increment unit, one slot per cycle
   assign phase_rd  = phase_ff[idx];
   assign phase_inc = phase_rd + 1'b1;
   assign wrap      = (phase_inc == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            phase_ff[s] <= '0;
         end
      end else if (cmd.clr) begin
         phase_ff[idx] <= '0;
      end else if (cmd.inc) begin
         phase_ff[idx] <= phase_inc;
      end
   end

endmodule

// File: src/rrts_scan_ctrl.sv
module rrts_scan_ctrl
   import rrts_pkg::*;
#(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     kind,
   input  logic [CUR_W-1:0]         current_slot,
   input  logic                     current_valid,
   input  logic [MASK_W-1:0]        ready_mask,
   input  logic [MASK_W-1:0]        throttled_mask,
   input  logic                     phase_wrap,
   output phase_cmd_type            cmd,
   output logic [$clog2(SLOTS)-1:0] idx,
   input  logic                     out_free,
   output logic                     done,
   output result_type               result
);

   localparam int SW = $clog2(SLOTS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_POLICY = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SW-1:0]     ptr_ff, ptr_in;
   logic [SW-1:0]     cnt_ff, cnt_in;
   logic [MASK_W-1:0] ready_ff, ready_in;
   logic [MASK_W-1:0] thr_ff, thr_in;
   logic              have_fb_ff, have_fb_in;
   logic [SW-1:0]     fb_ff, fb_in;
   logic              found_ff, found_in;
   logic [SW-1:0]     pick_ff, pick_in;

   logic [CMP_W-1:0]      cur_ext;
   logic [SW-1:0]         start;
   logic [MASK_IDX_W-1:0] bit_idx;
   logic                  in_range;
   logic                  rdy_bit;
   logic                  thr_bit;
   logic                  take;
   logic                  last;
   logic [SW-1:0]         ptr_next;

   always_comb begin
      cur_ext = CMP_W'(current_slot);
      start = '0;
      if (current_valid && (cur_ext < CMP_W'(SLOTS))) begin
         if (cur_ext + 1'b1 != CMP_W'(SLOTS)) begin
            start = SW'(cur_ext + 1'b1);
         end
      end
   end

   // slots past the mask width read as not ready and not throttled
   assign bit_idx  = MASK_IDX_W'(ptr_ff);
   assign in_range = (CMP_W'(ptr_ff) < CMP_W'(MASK_W));
   assign rdy_bit  = in_range && ready_ff[bit_idx];
   assign thr_bit  = in_range && thr_ff[bit_idx];
   assign take     = rdy_bit && (!thr_bit || phase_wrap);
   assign last     = (cnt_ff == SW'(SLOTS - 1));
   assign ptr_next = (ptr_ff == SW'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;

   assign in_ready = (state_ff == ST_IDLE);
   assign idx      = ptr_ff;
   assign cmd.inc  = (state_ff == ST_SCAN) && rdy_bit && thr_bit;
   assign cmd.clr  = (state_ff == ST_POLICY) && !thr_bit;
   assign done     = (state_ff == ST_DONE) && out_free;
   assign result.selected_slot = SLOT_OUT_W'(pick_ff);
   assign result.found         = found_ff;

   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      cnt_in     = cnt_ff;
      ready_in   = ready_ff;
      thr_in     = thr_ff;
      have_fb_in = have_fb_ff;
      fb_in      = fb_ff;
      found_in   = found_ff;
      pick_in    = pick_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               ready_in   = ready_mask;
               thr_in     = throttled_mask;
               cnt_in     = '0;
               have_fb_in = 1'b0;
               fb_in      = '0;
               found_in   = 1'b0;
               pick_in    = '0;
               if (kind == KIND_POLICY) begin
                  ptr_in   = '0;
                  state_in = ST_POLICY;
               end else begin
                  ptr_in   = start;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rdy_bit && thr_bit && !have_fb_ff) begin
               have_fb_in = 1'b1;
               fb_in      = ptr_ff;
            end
            if (take) begin
               found_in = 1'b1;
               pick_in  = ptr_ff;
               state_in = ST_DONE;
            end else if (last) begin
               // nothing taken: fall back to the first throttled ready slot
               found_in = have_fb_in;
               pick_in  = have_fb_in ? fb_in : '0;
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_POLICY: begin
            if (last) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ptr_ff     <= ptr_in;
      cnt_ff     <= cnt_in;
      ready_ff   <= ready_in;
      thr_ff     <= thr_in;
      have_fb_ff <= have_fb_in;
      fb_ff      <= fb_in;
      found_ff   <= found_in;
      pick_ff    <= pick_in;
   end

endmodule

// File: src/round_robin_throttle_scheduler.sv
// Round-robin slot picker with thermal throttling.
// Channels: req_ch carries one item per scheduling decision (kind, current
// slot, ready and throttled masks); rsp_ch returns one item per request
// (selected_slot, found). Both use valid/ready; an item moves when both are high.
// A select item scans the slots one per cycle starting after the current
// slot (slot 0 if current_slot is not valid or out of range), through the
// single shared skip-phase increment unit. The scan stops at the first slot
// taken or after all SLOTS slots. A policy item walks all SLOTS phases,
// one per cycle, clearing the phase of each slot that is not throttled.
// One item is in work at a time; req_ch.ready is high only while the
// sequencer is idle.
// The result sits in an output register, so a new item is accepted while the
// previous result still waits. If the receiver stalls, the finished item
// holds in the sequencer until the output register frees up.
// Reset (synchronous, active high) clears all skip phases to zero, empties
// the output register and returns the sequencer to idle.
module round_robin_throttle_scheduler
   import rrts_pkg::*;
#(
   parameter int SLOTS = DEF_SLOTS
) (
   input logic      clock,
   input logic      reset,
   rrts_req_if.sink   req_ch,
   rrts_rsp_if.source rsp_ch
);

   localparam int SW = $clog2(SLOTS);

   phase_cmd_type         cmd;
   logic [SW-1:0]         idx;
   logic                  phase_wrap;
   logic                  out_free;
   logic                  done;
   result_type            result;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;

   rrts_scan_ctrl #(
      .SLOTS(SLOTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_ch.valid),
      .in_ready      (req_ch.ready),
      .kind          (req_ch.kind),
      .current_slot  (req_ch.current_slot),
      .current_valid (req_ch.current_valid),
      .ready_mask    (req_ch.ready_mask),
      .throttled_mask(req_ch.throttled_mask),
      .phase_wrap    (phase_wrap),
      .cmd           (cmd),
      .idx           (idx),
      .out_free      (out_free),
      .done          (done),
      .result        (result)
   );

   rrts_phase_file #(
      .SLOTS(SLOTS)
   ) u_phase (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd),
      .idx  (idx),
      .wrap (phase_wrap)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.selected_slot = rsp_data_ff.selected_slot;
   assign rsp_ch.found         = rsp_data_ff.found;

endmodule
